@@ hdl/interval_alarm_timer_assert.svh @@
// -----------------------------------------------------------------------------
// interval_alarm_timer assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef INTERVAL_ALARM_TIMER_ASSERT_SVH
`define INTERVAL_ALARM_TIMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IAT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define IAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IAT_ASSERT_IMPL(lbl, ante, cons, msg)
`define IAT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/iat_pkg.sv @@
// -----------------------------------------------------------------------------
// iat_pkg
// Types and constants shared by the interval alarm timer modules.
// -----------------------------------------------------------------------------
package iat_pkg;

  localparam int unsigned TpsW    = 17;
  localparam int unsigned SecW    = 31;
  localparam int unsigned UsecW   = 20;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 31;
  localparam int unsigned DivNumW = 37;
  localparam int unsigned DivDenW = 20;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [UsecW-1:0] UsecPerSec    = 20'd1000000;
  localparam logic [UsecW-1:0] UsecMinusOne  = 20'd999999;
  localparam logic [SecW-1:0]  TickMax       = 31'h7FFF_FFFF;
  localparam logic [TpsW-1:0]  TpsReset      = 17'd100;
  localparam logic [SecW-1:0]  MaxSecReset   = 31'd100000000;

  // 10^6 is 2^6 times 15625; the division by 15625 is a multiply by a rounded-up
  // reciprocal, exact for every shifted numerator below 2^31.
  localparam int unsigned      UsecShift      = 6;
  localparam int unsigned      UsecRecipShift = 45;
  localparam int unsigned      RecipW         = 63;
  localparam logic [31:0]      UsecRecip      = 32'd2251799814;

  typedef enum logic [CfgIdxW-1:0] {CFG_TPS, CFG_MAX_SEC} cfg_idx_e;
  typedef enum logic [1:0] {OP_TICK, OP_SET, OP_GET, OP_ALARM} opcode_e;
  typedef enum logic {STAT_OK, STAT_INVALID} status_e;
  typedef enum logic [2:0] {KIND_TICK, KIND_SET, KIND_GET, KIND_ALARM, KIND_BAD_SET} kind_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SecW-1:0]  value_sec;
    logic [UsecW-1:0] value_usec;
    logic [SecW-1:0]  reload_sec;
    logic [UsecW-1:0] reload_usec;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [SecW-1:0]  old_value_sec;
    logic [UsecW-1:0] old_value_usec;
    logic [SecW-1:0]  old_reload_sec;
    logic [UsecW-1:0] old_reload_usec;
    logic [SecW-1:0]  remaining_whole_sec;
    logic             fired;
  } rsp_t;

  typedef struct packed {
    kind_e            kind;
    logic [SecW-1:0]  value_sec;
    logic [UsecW-1:0] value_usec;
    logic [SecW-1:0]  reload_sec;
    logic [UsecW-1:0] reload_usec;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OLD_SEC, ST_OLD_UMUL, ST_OLD_USEC, ST_RLD_SEC, ST_RLD_UMUL,
    ST_RLD_USEC, ST_VAL_SMUL, ST_VAL_UMUL, ST_VAL_DIV, ST_VAL_SUM, ST_IVL_SMUL,
    ST_IVL_UMUL, ST_IVL_DIV, ST_IVL_SUM, ST_OUT
  } step_e;

endpackage

@@ hdl/iat_div.sv @@
// -----------------------------------------------------------------------------
// iat_div
// Restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module iat_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [iat_pkg::DivNumW-1:0]    num_i,
  input  logic [iat_pkg::DivDenW-1:0]    den_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [iat_pkg::DivNumW-1:0]    quo_o,
  output logic [iat_pkg::DivDenW-1:0]    rem_o
);
  import iat_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivDenW-1:0] den_q, den_d, rem_q, rem_d;
  logic [DivDenW:0]   trial;

  assign trial = {rem_q, num_q[DivNumW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivNumW);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // The quotient bits shift in where the dividend bits leave.
      if (trial >= {1'b0, den_q}) begin
        rem_d = DivDenW'(trial - {1'b0, den_q});
        num_d = {num_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivDenW-1:0];
        num_d = {num_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/iat_front.sv @@
// -----------------------------------------------------------------------------
// iat_front
// Accepts requests, checks set requests for sane times and queues commands.
// -----------------------------------------------------------------------------
module iat_front #(
  parameter int unsigned Depth = iat_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  iat_pkg::req_t               in_req_i,
  input  logic [iat_pkg::SecW-1:0]    max_sec_i,
  input  logic                        pop_i,
  output logic                        cmd_valid_o,
  output iat_pkg::cmd_t               cmd_o
);
  import iat_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  cmd_t            cmd_in;
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop, sane;

  assign sane = (in_req_i.value_sec <= max_sec_i) && (in_req_i.value_usec < UsecPerSec) &&
                (in_req_i.reload_sec <= max_sec_i) && (in_req_i.reload_usec < UsecPerSec);

  always_comb begin
    cmd_in.value_sec   = in_req_i.value_sec;
    cmd_in.value_usec  = in_req_i.value_usec;
    cmd_in.reload_sec  = in_req_i.reload_sec;
    cmd_in.reload_usec = in_req_i.reload_usec;
    unique case (opcode_e'(in_req_i.opcode))
      OP_TICK:  cmd_in.kind = KIND_TICK;
      OP_SET:   cmd_in.kind = sane ? KIND_SET : KIND_BAD_SET;
      OP_GET:   cmd_in.kind = KIND_GET;
      OP_ALARM: cmd_in.kind = KIND_ALARM;
      default:  cmd_in.kind = KIND_TICK;
    endcase
  end

  assign in_stall_o  = (cnt_q == CntW'(Depth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

endmodule

@@ hdl/iat_back.sv @@
// -----------------------------------------------------------------------------
// iat_back
// Timer state and the sequencer that converts times with a shared divider.
// -----------------------------------------------------------------------------
module iat_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  iat_pkg::cmd_t               cmd_i,
  output logic                        pop_o,
  input  logic [iat_pkg::TpsW-1:0]    tps_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output iat_pkg::rsp_t               out_rsp_o
);
  import iat_pkg::*;
  `include "interval_alarm_timer_assert.svh"

  step_e            st_q, st_d;
  cmd_t             cmd_q, cmd_d;
  rsp_t             res_q, res_d;
  logic             armed_q, armed_d, pend_q, pend_d;
  logic [SecW-1:0]  left_q, left_d, reload_q, reload_d, newval_q, newval_d;
  logic [47:0]      prod_q, prod_d, mul_p;
  logic [SecW:0]    whole_q, whole_d, clip_p;
  logic [TpsW-1:0]  hz, mul_a;
  logic [SecW-1:0]  mul_b, old_t, sat_sum, alarm_sec, ceil_x;
  logic [SecW+1:0]  sum;
  logic [DivNumW-1:0] ceil_num;
  logic [RecipW-1:0]  recip_q, recip_d, recip_p;
  logic             div_start, div_busy, div_done, div_state, step_done;
  logic [DivNumW-1:0] div_num, div_quo;
  logic [DivDenW-1:0] div_den, div_rem;

  assign hz    = (tps_i == '0) ? TpsW'(1) : tps_i;
  assign old_t = !armed_q ? '0 : ((left_q != '0) ? left_q : reload_q);

  // One shared multiplier: rate times seconds or microseconds, remainder times 10^6.
  always_comb begin
    unique case (st_q)
      ST_OLD_UMUL, ST_RLD_UMUL: begin
        mul_a = div_rem[TpsW-1:0];
        mul_b = SecW'(UsecPerSec);
      end
      ST_VAL_SMUL: begin mul_a = hz; mul_b = cmd_q.value_sec; end
      ST_VAL_UMUL: begin mul_a = hz; mul_b = SecW'(cmd_q.value_usec); end
      ST_IVL_SMUL: begin mul_a = hz; mul_b = cmd_q.reload_sec; end
      ST_IVL_UMUL: begin mul_a = hz; mul_b = SecW'(cmd_q.reload_usec); end
      default:     begin mul_a = hz; mul_b = '0; end
    endcase
  end
  assign mul_p  = 48'(mul_a) * 48'(mul_b);
  // Whole ticks clipped just above the largest count, so the later sum saturates.
  assign clip_p = (mul_p[47:SecW] != '0) ? {1'b1, {SecW{1'b0}}} : {1'b0, mul_p[SecW-1:0]};

  // Rounded-up ticks from microseconds: drop the factor 2^6 of 10^6 with a shift,
  // then divide by 15625 through the reciprocal.
  assign ceil_num = prod_q[DivNumW-1:0] + DivNumW'(UsecMinusOne);
  assign ceil_x   = ceil_num[DivNumW-1:UsecShift];
  assign recip_p  = RecipW'(ceil_x) * RecipW'(UsecRecip);

  always_comb begin
    unique case (st_q)
      ST_OLD_SEC:  begin div_num = DivNumW'(old_t);    div_den = DivDenW'(hz); end
      ST_RLD_SEC:  begin div_num = DivNumW'(reload_q); div_den = DivDenW'(hz); end
      ST_OLD_USEC, ST_RLD_USEC: begin
        div_num = prod_q[DivNumW-1:0];
        div_den = DivDenW'(hz);
      end
      default: begin
        div_num = '0;
        div_den = DivDenW'(hz);
      end
    endcase
  end

  assign div_state = (st_q == ST_OLD_SEC) || (st_q == ST_OLD_USEC) ||
                     (st_q == ST_RLD_SEC) || (st_q == ST_RLD_USEC);
  assign div_start = div_state && !pend_q;
  assign step_done = div_done && pend_q;

  assign sum     = {1'b0, whole_q} + (SecW + 2)'(recip_q[RecipW-1:UsecRecipShift]);
  assign sat_sum = (sum > (SecW + 2)'(TickMax)) ? TickMax : sum[SecW-1:0];
  assign alarm_sec = (res_q.old_value_usec != '0) && (res_q.old_value_sec != TickMax) ?
                     res_q.old_value_sec + 1'b1 : res_q.old_value_sec;

  iat_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // Next step.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            KIND_SET, KIND_GET, KIND_ALARM: st_d = ST_OLD_SEC;
            default:                        st_d = ST_OUT;
          endcase
        end
      end
      ST_OLD_SEC:  if (step_done) st_d = ST_OLD_UMUL;
      ST_OLD_UMUL: st_d = ST_OLD_USEC;
      ST_OLD_USEC: if (step_done) st_d = ST_RLD_SEC;
      ST_RLD_SEC:  if (step_done) st_d = ST_RLD_UMUL;
      ST_RLD_UMUL: st_d = ST_RLD_USEC;
      ST_RLD_USEC: if (step_done) st_d = (cmd_q.kind == KIND_GET) ? ST_OUT : ST_VAL_SMUL;
      ST_VAL_SMUL: st_d = (cmd_q.kind == KIND_ALARM) ? ST_OUT : ST_VAL_UMUL;
      ST_VAL_UMUL: st_d = ST_VAL_DIV;
      ST_VAL_DIV:  st_d = ST_VAL_SUM;
      ST_VAL_SUM:  st_d = ST_IVL_SMUL;
      ST_IVL_SMUL: st_d = ST_IVL_UMUL;
      ST_IVL_UMUL: st_d = ST_IVL_DIV;
      ST_IVL_DIV:  st_d = ST_IVL_SUM;
      ST_IVL_SUM:  st_d = ST_OUT;
      ST_OUT:      if (!out_stall_i) st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  // Datapath and timer state updates.
  always_comb begin
    cmd_d    = cmd_q;
    res_d    = res_q;
    armed_d  = armed_q;
    left_d   = left_q;
    reload_d = reload_q;
    newval_d = newval_q;
    prod_d   = prod_q;
    whole_d  = whole_q;
    recip_d  = recip_q;
    pop_o    = 1'b0;
    pend_d   = pend_q;
    if (div_start) begin
      pend_d = 1'b1;
    end else if (step_done) begin
      pend_d = 1'b0;
    end
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          res_d = '0;
          if (cmd_i.kind == KIND_BAD_SET) begin
            res_d.status = STAT_INVALID;
          end else if (cmd_i.kind == KIND_TICK) begin
            if (armed_q && (left_q != '0)) begin
              left_d = left_q - 1'b1;
              if (left_q == SecW'(1)) begin
                res_d.fired = 1'b1;
                if (reload_q != '0) begin
                  left_d = reload_q;
                end else begin
                  armed_d = 1'b0;
                end
              end
            end
          end
        end
      end
      ST_OLD_SEC:  if (step_done) res_d.old_value_sec = div_quo[SecW-1:0];
      ST_OLD_USEC: if (step_done) res_d.old_value_usec = div_quo[UsecW-1:0];
      ST_RLD_SEC:  if (step_done) res_d.old_reload_sec = div_quo[SecW-1:0];
      ST_RLD_USEC: if (step_done) res_d.old_reload_usec = div_quo[UsecW-1:0];
      ST_OLD_UMUL, ST_RLD_UMUL, ST_VAL_UMUL, ST_IVL_UMUL: prod_d = mul_p;
      ST_VAL_SMUL: begin
        whole_d = clip_p;
        if (cmd_q.kind == KIND_ALARM) begin
          res_d.remaining_whole_sec = alarm_sec;
          armed_d  = (clip_p != '0);
          left_d   = clip_p[SecW] ? TickMax : clip_p[SecW-1:0];
          reload_d = '0;
        end
      end
      ST_VAL_DIV, ST_IVL_DIV: recip_d = recip_p;
      ST_VAL_SUM:  newval_d = sat_sum;
      ST_IVL_SMUL: whole_d = clip_p;
      ST_IVL_SUM: begin
        armed_d  = (newval_q != '0);
        left_d   = newval_q;
        reload_d = (newval_q != '0) ? sat_sum : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      pend_q   <= 1'b0;
      armed_q  <= 1'b0;
      left_q   <= '0;
      reload_q <= '0;
    end else begin
      st_q     <= st_d;
      pend_q   <= pend_d;
      armed_q  <= armed_d;
      left_q   <= left_d;
      reload_q <= reload_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    res_q    <= res_d;
    newval_q <= newval_d;
    prod_q   <= prod_d;
    whole_q  <= whole_d;
    recip_q  <= recip_d;
  end

  assign out_valid_o = (st_q == ST_OUT);
  assign out_rsp_o   = res_q;

  `IAT_ASSERT_IMPL(a_disarmed_clear, !armed_q, (left_q | reload_q) == '0, "count while off")
  `IAT_ASSERT_IMPL(a_armed_count, armed_q, left_q != '0, "armed timer with zero count")
  `IAT_ASSERT_IMPL(a_div_idle_start, div_start, !div_busy, "divider started while busy")
  `IAT_ASSERT_NEXT(a_fired_tick, pop_o && (cmd_i.kind != KIND_TICK), !res_q.fired, "stray fire")

endmodule

@@ hdl/interval_alarm_timer.sv @@
// -----------------------------------------------------------------------------
// interval_alarm_timer
// One real interval timer with set, get, alarm and tick requests.
// -----------------------------------------------------------------------------
// A tick or an invalid set needs no division; a get, an alarm and a valid set
// first read back the old value and reload. A readback is four divisions by the
// rate on one bit-serial divider. The back end works on one request at a time;
// the front queue keeps taking requests meanwhile, until it is full. Reset is
// asynchronous, active low: the timer is disarmed, counts are zero, and the
// rate and seconds limit return to 100 and 100000000.
module interval_alarm_timer #(
  parameter int unsigned QueueDepth = iat_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  iat_pkg::req_t                in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output iat_pkg::rsp_t                out_rsp_o,
  input  logic                         cfg_we_i,
  input  logic [iat_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [iat_pkg::CfgW-1:0]     cfg_wdata_i
);
  import iat_pkg::*;

  logic [TpsW-1:0] tps_q, tps_d;
  logic [SecW-1:0] max_sec_q, max_sec_d;
  logic            cmd_valid, pop;
  cmd_t            cmd;

  always_comb begin
    tps_d     = tps_q;
    max_sec_d = max_sec_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TPS:     tps_d = cfg_wdata_i[TpsW-1:0];
        CFG_MAX_SEC: max_sec_d = cfg_wdata_i[SecW-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q     <= TpsReset;
      max_sec_q <= MaxSecReset;
    end else begin
      tps_q     <= tps_d;
      max_sec_q <= max_sec_d;
    end
  end

  iat_front #(.Depth(QueueDepth)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .max_sec_i   (max_sec_q),
    .pop_i       (pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  iat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .tps_i       (tps_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
